// ===== rtl/core/mse_pkg.sv =====
`timescale 1ns / 1ps
// mse_pkg: shared constants, types and codes for the mean and standard error unit
// depends on nothing
package mse_pkg;

  localparam int MAX_SAMPLES = 1024;
  localparam int ADDR_W = $clog2(MAX_SAMPLES);
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = 32 + CNT_W;
  localparam int DEV_W  = 48 + CNT_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int DVD_W  = DEV_W + 16;
  localparam int STEP_W = $clog2(DVD_W + 1);
  localparam int SQ_STEPS = 32;
  localparam int REM_W  = 36;

  typedef enum logic [1:0] {
    KIND_ADD       = 2'd0,
    KIND_ADD_CLOSE = 2'd1,
    KIND_CLOSE     = 2'd2,
    KIND_NONE      = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_SINGLE = 2'd2,
    ST_DROP   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MEAN,
    BK_PASS,
    BK_VDIV,
    BK_SQRT,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    logic                    ovf;
    logic [CNT_W-1:0]        cnt;
    logic signed [SUM_W-1:0] sum;
  } job_t;

  typedef struct packed {
    logic pop;
    logic release_ram;
    logic ram_re;
    logic load_out;
  } bk_ctrl_t;

endpackage

// ===== rtl/core/mse_if.sv =====
`timescale 1ns / 1ps
// mse_in_if / mse_out_if: valid-ready channels for sample beats and result beats
// depends on nothing
interface mse_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic signed [31:0] sample;
  modport source (output valid, kind, sample, input ready);
  modport sink (input valid, kind, sample, output ready);
endinterface

interface mse_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] mean;
  logic [31:0]        std_error;
  logic [1:0]         status;
  modport source (output valid, mean, std_error, status, input ready);
  modport sink (input valid, mean, std_error, status, output ready);
endinterface

// ===== rtl/core/mse_ram.sv =====
`timescale 1ns / 1ps
// mse_ram: generic single write port, single read port ram with registered read
// depends on nothing
module mse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mse_fifo.sv =====
`timescale 1ns / 1ps
// mse_fifo: two-entry queue of closed-set jobs between front and back
// depends on mse_pkg
module mse_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mse_pkg::job_t push_job_i,
  input  logic          pop_i,
  output mse_pkg::job_t head_o,
  output logic          empty_o,
  output logic          full_o
);

  mse_pkg::job_t slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_job_i;
    end
  end

  assign head_o  = slot_q[rd_q];
  assign empty_o = (fill_q == 2'd0);
  assign full_o  = (fill_q == 2'd2);

endmodule

// ===== rtl/core/mse_front.sv =====
`timescale 1ns / 1ps
// mse_front: takes sample beats, writes the store, keeps count, sum and drop flag
// depends on mse_pkg, mse_if
module mse_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  mse_in_if.sink                      in_i,
  input  logic                        q_full_i,
  input  logic                        release_i,
  output logic                        push_o,
  output mse_pkg::job_t               push_job_o,
  output logic                        ram_we_o,
  output logic [mse_pkg::ADDR_W-1:0]  ram_waddr_o,
  output logic [31:0]                 ram_wdata_o
);

  logic [mse_pkg::CNT_W-1:0]        count_q, count_d;
  logic signed [mse_pkg::SUM_W-1:0] sum_q, sum_d;
  logic                             ovf_q, ovf_d;
  logic                             lock_q;
  logic                             accept, is_add, is_close, room, take;

  assign in_i.ready = !lock_q && !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_add     = (in_i.kind == mse_pkg::KIND_ADD) || (in_i.kind == mse_pkg::KIND_ADD_CLOSE);
  assign is_close   = (in_i.kind == mse_pkg::KIND_ADD_CLOSE) || (in_i.kind == mse_pkg::KIND_CLOSE);
  assign room       = count_q < mse_pkg::CNT_W'(mse_pkg::MAX_SAMPLES);
  assign take       = accept && is_add && room;

  always_comb begin
    count_d = count_q + mse_pkg::CNT_W'(take);
    sum_d   = take ? sum_q + mse_pkg::SUM_W'(in_i.sample) : sum_q;
    ovf_d   = ovf_q || (accept && is_add && !room);
  end

  assign push_o          = accept && is_close;
  assign push_job_o.ovf  = ovf_d;
  assign push_job_o.cnt  = count_d;
  assign push_job_o.sum  = sum_d;
  assign ram_we_o        = take;
  assign ram_waddr_o     = count_q[mse_pkg::ADDR_W-1:0];
  assign ram_wdata_o     = in_i.sample;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_q   <= '0;
      ovf_q   <= 1'b0;
      lock_q  <= 1'b0;
    end else begin
      if (push_o) begin
        count_q <= '0;
        sum_q   <= '0;
        ovf_q   <= 1'b0;
        lock_q  <= 1'b1;
      end else begin
        count_q <= count_d;
        sum_q   <= sum_d;
        ovf_q   <= ovf_d;
        if (release_i) begin
          lock_q <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== rtl/core/mse_back.sv =====
`timescale 1ns / 1ps
// mse_back: per job mean divide, deviation pass over the store, variance divide,
// square root and result register; depends on mse_pkg, mse_if
module mse_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_empty_i,
  input  mse_pkg::job_t              job_i,
  output mse_pkg::bk_ctrl_t          ctrl_o,
  output logic [mse_pkg::ADDR_W-1:0] ram_raddr_o,
  input  logic [31:0]                ram_rdata_i,
  mse_out_if.source                  out_o
);

  localparam int DVD_W = mse_pkg::DVD_W;
  localparam int DEN_W = mse_pkg::DEN_W;
  localparam int CNT_W = mse_pkg::CNT_W;

  mse_pkg::bk_state_e state_q, state_d;
  mse_pkg::bk_ctrl_t  ctrl;

  logic [CNT_W-1:0]          n_q, iss_q;
  logic                      neg_q, ovf_q;
  logic [DEN_W-1:0]          den_q, dvs_q;
  logic [DVD_W-1:0]          dvd_q;
  logic [DEN_W-1:0]          drem_q;
  logic [mse_pkg::STEP_W-1:0] step_q;
  logic signed [31:0]        mean_q;
  logic [31:0]               err_q;
  logic [1:0]                st_q;
  logic                      v1_q, v2_q;
  logic [63:0]               prod_q;
  logic [mse_pkg::DEV_W-1:0] dev_q;
  logic [63:0]               x_q;
  logic [31:0]               root_q;
  logic [mse_pkg::REM_W-1:0] srem_q;
  logic                      out_valid_q;
  logic signed [31:0]        out_mean_q;
  logic [31:0]               out_err_q;
  logic [1:0]                out_st_q;

  logic [DEN_W:0]            dtry;
  logic                      dbit;
  logic [DEN_W-1:0]          drem_n;
  logic [DVD_W-1:0]          dvd_n;
  logic [mse_pkg::REM_W-1:0] stry, strial, srem_n;
  logic [31:0]               root_n;
  logic                      sbit;
  logic                      last_step, pass_done;
  logic [mse_pkg::SUM_W-1:0] mag;
  logic signed [32:0]        diff;
  logic [31:0]               absd;
  logic [48:0]               sq;
  logic [31:0]               qmean;

  // one restoring divide step
  always_comb begin
    dtry   = {drem_q, dvd_q[DVD_W-1]};
    dbit   = dtry >= {1'b0, dvs_q};
    drem_n = dbit ? DEN_W'(dtry - {1'b0, dvs_q}) : dtry[DEN_W-1:0];
    dvd_n  = {dvd_q[DVD_W-2:0], dbit};
  end

  // one square root step, two radicand bits
  always_comb begin
    stry   = {srem_q[mse_pkg::REM_W-3:0], x_q[63:62]};
    strial = {{(mse_pkg::REM_W-34){1'b0}}, root_q, 2'b01};
    sbit   = stry >= strial;
    srem_n = sbit ? stry - strial : stry;
    root_n = {root_q[30:0], sbit};
  end

  assign last_step = (step_q == mse_pkg::STEP_W'(1));
  assign pass_done = (iss_q == n_q) && !v1_q && !v2_q;
  assign mag       = job_i.sum[mse_pkg::SUM_W-1] ? mse_pkg::SUM_W'(-job_i.sum)
                                                  : mse_pkg::SUM_W'(job_i.sum);
  assign qmean     = dvd_n[31:0];
  assign diff      = 33'(signed'(ram_rdata_i)) - 33'(mean_q);
  assign absd      = diff[32] ? 32'(-diff) : diff[31:0];
  assign sq        = 49'((65'(prod_q) + 65'h8000) >> 16);

  always_comb begin
    state_d = state_q;
    case (state_q)
      mse_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (job_i.cnt == '0) ? mse_pkg::BK_OUT : mse_pkg::BK_MEAN;
        end
      end
      mse_pkg::BK_MEAN: begin
        if (last_step) begin
          state_d = mse_pkg::BK_PASS;
        end
      end
      mse_pkg::BK_PASS: begin
        if (pass_done) begin
          state_d = (n_q == CNT_W'(1)) ? mse_pkg::BK_OUT : mse_pkg::BK_VDIV;
        end
      end
      mse_pkg::BK_VDIV: begin
        if (last_step) begin
          state_d = (dvd_n[DVD_W-1:64] != '0) ? mse_pkg::BK_OUT : mse_pkg::BK_SQRT;
        end
      end
      mse_pkg::BK_SQRT: begin
        if (last_step) begin
          state_d = mse_pkg::BK_OUT;
        end
      end
      mse_pkg::BK_OUT: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = mse_pkg::BK_IDLE;
        end
      end
      default: state_d = mse_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    case (state_q)
      mse_pkg::BK_IDLE: begin
        ctrl.pop         = !q_empty_i;
        ctrl.release_ram = !q_empty_i && (job_i.cnt == '0);
      end
      mse_pkg::BK_PASS: begin
        ctrl.ram_re      = iss_q != n_q;
        ctrl.release_ram = pass_done;
      end
      mse_pkg::BK_OUT: begin
        ctrl.load_out = !out_valid_q || out_o.ready;
      end
      default: ctrl = '0;
    endcase
  end

  assign ctrl_o      = ctrl;
  assign ram_raddr_o = iss_q[mse_pkg::ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mse_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
    end else begin
      state_q <= state_d;
      v1_q    <= ctrl.ram_re;
      v2_q    <= v1_q;
      if (ctrl.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      prod_q <= 64'(absd) * 64'(absd);
    end
    if (v2_q) begin
      dev_q <= dev_q + mse_pkg::DEV_W'(sq);
    end
    if (ctrl.ram_re) begin
      iss_q <= iss_q + CNT_W'(1);
    end
    if (ctrl.load_out) begin
      out_mean_q <= mean_q;
      out_err_q  <= err_q;
      out_st_q   <= st_q;
    end
    case (state_q)
      mse_pkg::BK_IDLE: begin
        n_q    <= job_i.cnt;
        neg_q  <= job_i.sum[mse_pkg::SUM_W-1];
        ovf_q  <= job_i.ovf;
        den_q  <= DEN_W'(job_i.cnt) * DEN_W'(job_i.cnt - CNT_W'(1));
        dvs_q  <= DEN_W'(job_i.cnt);
        dvd_q  <= DVD_W'(mag + mse_pkg::SUM_W'(job_i.cnt >> 1));
        drem_q <= '0;
        step_q <= mse_pkg::STEP_W'(DVD_W);
        mean_q <= '0;
        err_q  <= 32'h0001_0000;
        st_q   <= mse_pkg::ST_EMPTY;
      end
      mse_pkg::BK_MEAN: begin
        dvd_q  <= dvd_n;
        drem_q <= drem_n;
        step_q <= step_q - mse_pkg::STEP_W'(1);
        if (last_step) begin
          mean_q <= neg_q ? -signed'(qmean) : signed'(qmean);
          iss_q  <= '0;
          dev_q  <= '0;
        end
      end
      mse_pkg::BK_PASS: begin
        if (pass_done) begin
          dvd_q  <= {dev_q, 16'h0000};
          dvs_q  <= den_q;
          drem_q <= '0;
          step_q <= mse_pkg::STEP_W'(DVD_W);
          err_q  <= 32'hFFFF_FFFF;
          st_q   <= (n_q == CNT_W'(1)) ? mse_pkg::ST_SINGLE
                  : (ovf_q ? mse_pkg::ST_DROP : mse_pkg::ST_OK);
        end
      end
      mse_pkg::BK_VDIV: begin
        dvd_q  <= dvd_n;
        drem_q <= drem_n;
        if (last_step) begin
          x_q    <= dvd_n[63:0];
          root_q <= '0;
          srem_q <= '0;
          step_q <= mse_pkg::STEP_W'(mse_pkg::SQ_STEPS);
        end else begin
          step_q <= step_q - mse_pkg::STEP_W'(1);
        end
      end
      mse_pkg::BK_SQRT: begin
        x_q    <= {x_q[61:0], 2'b00};
        root_q <= root_n;
        srem_q <= srem_n;
        step_q <= step_q - mse_pkg::STEP_W'(1);
        if (last_step) begin
          // round to nearest, saturate on carry out
          if (srem_n > mse_pkg::REM_W'(root_n)) begin
            err_q <= (root_n == 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : root_n + 32'd1;
          end else begin
            err_q <= root_n;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.mean      = out_mean_q;
  assign out_o.std_error = out_err_q;
  assign out_o.status    = out_st_q;

endmodule

// ===== rtl/core/mean_and_standard_error_unit.sv =====
`timescale 1ns / 1ps
// mean_and_standard_error_unit: top level, front, job queue, sample store and back
// depends on mse_pkg, mse_if, mse_ram, mse_fifo, mse_front, mse_back
//
//  channel  dir  payload                     beat
//  in_i     in   kind[1:0], sample[31:0]     valid && ready
//  out_o    out  mean, std_error, status     valid && ready
//
// sample beats are taken one per cycle while a set loads and the job queue has room
// a close holds the input until the back has read the set from the store;
// the mean divide comes before that read, the variance divide and the square root
// after it, so the next set can load while those two run
// the result register lets the back start the next set while out_o stalls
// reset is asynchronous, active low; the store needs no clearing
module mean_and_standard_error_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  mse_in_if.sink    in_i,
  mse_out_if.source out_o
);

  logic                       push, q_full, q_empty;
  mse_pkg::job_t              push_job, head_job;
  mse_pkg::bk_ctrl_t          bk_ctrl;
  logic                       ram_we;
  logic [mse_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [31:0]                ram_wdata, ram_rdata;

  mse_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .release_i   (bk_ctrl.release_ram),
    .push_o      (push),
    .push_job_o  (push_job),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  mse_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_job_i (push_job),
    .pop_i      (bk_ctrl.pop),
    .head_o     (head_job),
    .empty_o    (q_empty),
    .full_o     (q_full)
  );

  mse_ram #(
    .WIDTH (32),
    .DEPTH (mse_pkg::MAX_SAMPLES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (bk_ctrl.ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  mse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .job_i       (head_job),
    .ctrl_o      (bk_ctrl),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .out_o       (out_o)
  );

  a_no_store_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && bk_ctrl.ram_re))
    else $error("store written during deviation pass");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("job pushed into full queue");

  a_release_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && bk_ctrl.release_ram))
    else $error("store released in the cycle of a close");

endmodule

// ===== bench/mse_checker.sv =====
`timescale 1ns / 1ps
// mse_checker: watches the sample and result channels, predicts each result and compares
// depends on mse_pkg and mse_if
module mse_checker (
  input  logic      clk_i,
  input  logic      rst_ni,
  mse_in_if.sink    in_i,
  mse_out_if.sink   out_o,
  output int        err_cnt_o,
  output int        pending_o
);

  typedef struct {
    logic signed [31:0]   mean;
    logic [31:0]          std_error;
    mse_pkg::status_e     status;
  } stats_t;

  logic [31:0]          store_q [mse_pkg::MAX_SAMPLES];
  int unsigned          n_held;
  longint               sum_acc;
  bit                   dropped;
  stats_t               expected_q [$];

  function automatic longint unsigned floor_root(longint unsigned x,
                                                  output longint unsigned rem);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    rem = x;
    return res;
  endfunction

  function automatic stats_t close_stats();
    stats_t r;
    longint unsigned n, mag, q, dev, sq, ad, den, qq, rr, x, rem, s;
    longint m, d;
    n = n_held;
    if (n == 0) begin
      r.mean = 0;
      r.std_error = 32'h0001_0000;
      r.status = mse_pkg::ST_EMPTY;
      return r;
    end
    mag = (sum_acc < 0) ? -sum_acc : sum_acc;
    q = (mag + n / 2) / n;
    m = (sum_acc < 0) ? -longint'(q) : longint'(q);
    r.mean = m[31:0];
    dev = 0;
    for (int i = 0; i < n_held; i++) begin
      d = longint'($signed(store_q[i])) - m;
      ad = (d < 0) ? -d : d;
      sq = (ad * ad + 64'h8000) >> 16;
      if (dev > 64'hFFFF_FFFF_FFFF_FFFF - sq) dev = 64'hFFFF_FFFF_FFFF_FFFF;
      else dev += sq;
    end
    if (n == 1) begin
      r.std_error = 32'hFFFF_FFFF;
      r.status = mse_pkg::ST_SINGLE;
      return r;
    end
    den = n * (n - 1);
    qq = dev / den;
    rr = dev % den;
    if (qq >= (64'd1 << 48)) begin
      r.std_error = 32'hFFFF_FFFF;
    end else begin
      x = (qq << 16) + ((rr << 16) / den);
      s = floor_root(x, rem);
      if (rem > s) s++;
      r.std_error = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    end
    r.status = dropped ? mse_pkg::ST_DROP : mse_pkg::ST_OK;
    return r;
  endfunction

  task automatic take_sample(logic [31:0] v);
    if (n_held < mse_pkg::MAX_SAMPLES) begin
      store_q[n_held] = v;
      sum_acc += longint'($signed(v));
      n_held++;
    end else begin
      dropped = 1'b1;
    end
  endtask

  task automatic finish_set();
    expected_q.insert(expected_q.size(), close_stats());
    n_held = 0;
    sum_acc = 0;
    dropped = 1'b0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    stats_t e;
    if (!rst_ni) begin
      n_held = 0;
      sum_acc = 0;
      dropped = 1'b0;
      err_cnt_o = 0;
      expected_q.delete();
      pending_o = 0;
    end else begin
      if (in_i.valid && in_i.ready) begin
        case (mse_pkg::kind_e'(in_i.kind))
          mse_pkg::KIND_ADD: take_sample(in_i.sample);
          mse_pkg::KIND_ADD_CLOSE: begin
            take_sample(in_i.sample);
            finish_set();
          end
          mse_pkg::KIND_CLOSE: finish_set();
          default: ;
        endcase
      end
      if (out_o.valid && out_o.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat mean=%h err=%h status=%0d", $time,
                   out_o.mean, out_o.std_error, out_o.status);
          err_cnt_o++;
        end else begin
          e = expected_q.pop_front();
          if (out_o.mean !== e.mean) begin
            $display("%0t: mean expected %h actual %h", $time, e.mean, out_o.mean);
            err_cnt_o++;
          end
          if (out_o.std_error !== e.std_error) begin
            $display("%0t: std_error expected %h actual %h", $time, e.std_error,
                     out_o.std_error);
            err_cnt_o++;
          end
          if (out_o.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_o.status);
            err_cnt_o++;
          end
        end
      end
      pending_o = expected_q.size();
    end
  end
endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// testbench: drives sample, close and no-op beats with random gaps, stalls the result side
// depends on mse_pkg, mse_if, mse_checker and the mean_and_standard_error_unit rtl
module testbench;

  localparam int WATCH_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   err_cnt, pending, idle_cycles;
  bit   sink_busy;

  mse_in_if  in_ch ();
  mse_out_if out_ch ();

  always #2 clk_i = ~clk_i;

  mean_and_standard_error_unit dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch),
                                    .out_o(out_ch));
  mse_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch),
                   .err_cnt_o(err_cnt), .pending_o(pending));

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = mse_pkg::KIND_ADD;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1: return $urandom_range(0, 3) - 2;
      2: return $urandom_range(0, 65535) << 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic send(mse_pkg::kind_e k, logic [31:0] v);
    int g;
    g = gap_len();
    repeat (g) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind <= k;
    in_ch.sample <= v;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_set(int n, bit close_on_last);
    for (int i = 0; i < n; i++)
      send((close_on_last && i == n - 1) ? mse_pkg::KIND_ADD_CLOSE : mse_pkg::KIND_ADD,
           rand_sample());
    if (!close_on_last) send(mse_pkg::KIND_CLOSE, '0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // result side stalls
  always @(posedge clk_i) begin
    int p;
    if (rst_ni && !sink_busy) begin
      p = $urandom_range(0, 99);
      if (p < 3) sink_busy = 1'b1;
      out_ch.ready <= (p >= 30) || (p < 3 && 1'b0);
    end else if (sink_busy) begin
      out_ch.ready <= 1'b0;
      if ($urandom_range(0, 29) == 0) sink_busy = 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int items, k;
    bit c;
    sink_busy = 1'b0;
    idle_cycles = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(mse_pkg::KIND_CLOSE, '0);
    send(mse_pkg::KIND_ADD_CLOSE, 32'h7FFF_FFFF);
    send(mse_pkg::KIND_ADD, 32'h8000_0000);
    send(mse_pkg::KIND_NONE, 32'hFFFF_FFFF);
    send(mse_pkg::KIND_ADD_CLOSE, 32'h7FFF_FFFF);
    send(mse_pkg::KIND_ADD, 32'h0001_0000);
    send(mse_pkg::KIND_ADD, 32'h0002_0000);
    send(mse_pkg::KIND_CLOSE, 32'hFFFF_FFFF);
    send(mse_pkg::KIND_ADD, 32'hFFFF_FFFF);
    send(mse_pkg::KIND_ADD_CLOSE, 32'h0000_0000);
    send(mse_pkg::KIND_ADD, 32'h8000_0000);
    send(mse_pkg::KIND_ADD, 32'h8000_0000);
    send(mse_pkg::KIND_ADD_CLOSE, 32'h8000_0000);
    send(mse_pkg::KIND_ADD, 32'h5555_AAAA);
    send(mse_pkg::KIND_ADD_CLOSE, 32'hAAAA_5555);
    drain();

    // full store with drops
    for (int i = 0; i < mse_pkg::MAX_SAMPLES + 3; i++) send(mse_pkg::KIND_ADD, rand_sample());
    send(mse_pkg::KIND_CLOSE, '0);
    drain();

    items = 0;
    while (items < 200) begin
      k = $urandom_range(0, 19);
      if (k == 0) begin
        send(mse_pkg::kind_e'($urandom_range(2, 3)), $urandom());
        items++;
      end else begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 6);
        c = $urandom_range(0, 1);
        send_set(k, c);
        items += c ? k : k + 1;
      end
      if ($urandom_range(0, 30) == 0) drain();
    end
    drain();
    repeat (400) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
